// ===== src/csvfs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csvfs_pkg: shared types and constants of the csv row field splitter
// Character codes, row status codes and the control/status bundles that pass
// between the sequencer and the datapath.
// ---------------------------------------------------------------------------
package csvfs_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_QUOTE = 2'd1;
    localparam logic [1:0] ST_BLANK = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    // commands from the sequencer
    typedef struct packed {
        logic       take;
        logic       scan;
        logic       put_last;
        logic       put_trail;
        logic       put_stat;
        logic       row_done;
        logic [1:0] stat;
    } csvfs_cmd_t;

    // status back to the sequencer
    typedef struct packed {
        logic ev_blank_end;
        logic ev_quote_err;
        logic ev_close;
        logic ev_trail;
        logic ev_field_end;
        logic scan_end;
        logic out_free;
    } csvfs_sts_t;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage
`default_nettype wire

// ===== src/csv_row_field_splitter_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csv_row_field_splitter_top: splits a csv row into cleaned fields
// Splits at unquoted, unescaped commas, trims whitespace, drops quotes and
// escapes, and flags unmatched quotes, blank row starts and field overflow.
// ---------------------------------------------------------------------------
//  channel | dir | tdata           | tlast      | tuser
//  s_      | in  | [7:0] in_char   | row_last   | -
//  m_      | out | [7:0] out_char  | field_last | [0] char_present, [1] row_done,
//          |     |                 |            | [3:2] row_status
//
//  row bytes are taken one per cycle while the sequencer waits for input; a
//  closing byte starts the replay of the buffered bytes between the trimmed
//  ends through the single read port: buffer read, end-of-scan check and
//  closing beat; a trailing comma or status-only beat adds a beat of its own
//  no input beat is taken while a field is replayed; m_ stalls hold the replay
//  synchronous active-low reset; buffer contents are not cleared
module csv_row_field_splitter_top import csvfs_pkg::*; #(
    parameter int FIELD_MAX = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_char
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tlast,
    output logic [3:0]      m_tuser    // [0] char_present, [1] row_done, [3:2] row_status
);

    csvfs_cmd_t cmd;
    csvfs_sts_t sts;

    csvfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csvfs_datapath #(
        .FIELD_MAX (FIELD_MAX)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== src/csvfs_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csvfs_ctrl: sequencer of the csv row field splitter
// Takes row bytes, then walks the datapath through the replay of a closed
// field, its closing beat, a trailing empty field or a status-only beat.
// ---------------------------------------------------------------------------
module csvfs_ctrl import csvfs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire csvfs_sts_t sts,
    output csvfs_cmd_t      cmd
);

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_TRAIL = 3'd3;
    localparam logic [2:0] S_STAT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;
    logic       trail_reg, trail_next;
    logic [1:0] stat_reg, stat_next;
    logic       acc;

    assign s_tready = (state_reg == S_IN);
    assign acc      = s_tready && s_tvalid;

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        trail_next = trail_reg;
        stat_next  = stat_reg;
        case (state_reg)
            S_IN: begin
                if (acc) begin
                    if (sts.ev_blank_end) begin
                        stat_next  = ST_BLANK;
                        state_next = S_STAT;
                    end else if (sts.ev_quote_err) begin
                        stat_next  = ST_QUOTE;
                        state_next = S_STAT;
                    end else if (sts.ev_close) begin
                        done_next  = 1'b0;
                        trail_next = sts.ev_trail;
                        state_next = S_SCAN;
                    end else if (sts.ev_field_end) begin
                        done_next  = 1'b1;
                        trail_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (sts.scan_end) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                if (sts.out_free) begin
                    state_next = trail_reg ? S_TRAIL : S_IN;
                end
            end
            S_TRAIL, S_STAT: begin
                if (sts.out_free) begin
                    state_next = S_IN;
                end
            end
            default: begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IN;
            done_reg  <= 1'b0;
            trail_reg <= 1'b0;
            stat_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            trail_reg <= trail_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb begin
        cmd.take      = s_tready;
        cmd.scan      = (state_reg == S_SCAN);
        cmd.put_last  = (state_reg == S_LAST) && sts.out_free;
        cmd.put_trail = (state_reg == S_TRAIL) && sts.out_free;
        cmd.put_stat  = (state_reg == S_STAT) && sts.out_free;
        cmd.row_done  = done_reg;
        cmd.stat      = stat_reg;
    end

endmodule
`default_nettype wire

// ===== src/csvfs_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csvfs_datapath: field buffer, row state, replay cleaner and result register
// Buffers the raw bytes of a field with its trimmed bounds, then reads them
// back one per cycle unless the result side stalls, drops quotes and escapes
// and holds each cleaned byte back so the last one can carry the field end mark.
// ---------------------------------------------------------------------------
module csvfs_datapath import csvfs_pkg::*; #(
    parameter int FIELD_MAX = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    input  wire csvfs_cmd_t cmd,
    output csvfs_sts_t      sts,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic [3:0]      m_tuser
);

    localparam int AW = $clog2(FIELD_MAX);
    localparam int LW = $clog2(FIELD_MAX + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(FIELD_MAX);
    localparam logic [LW-1:0] ONE     = LW'(1);

    logic [7:0] mem [FIELD_MAX];

    // row and field state
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] lo_reg, lo_next;
    logic [LW-1:0] hi_reg, hi_next;
    logic          any_reg, any_next;
    logic          inq_reg, inq_next;
    logic          esc_reg, esc_next;
    logic          start_reg, start_next;
    logic          blank_reg, blank_next;
    logic          ovf_reg, ovf_next;

    // replay state
    logic [LW-1:0] ia_reg, ia_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic          proc_v_reg, proc_v_next;
    logic          sesc_reg, sesc_next;
    logic          sq_reg, sq_next;
    logic          pq_reg, pq_next;
    logic          hold_v_reg, hold_v_next;
    logic [7:0]    hold_c_reg, hold_c_next;
    logic [7:0]    rd_data_reg;

    // result register
    logic          mv_reg, mv_next;
    logic [7:0]    mc_reg, mc_next;
    logic          mp_reg, mp_next;
    logic          ml_reg, ml_next;
    logic          md_reg, md_next;
    logic [1:0]    ms_reg, ms_next;

    logic          acc, blank_now, closed, store, room, wr_en, nonws;
    logic          want_issue, issue, proc_go, p_last, out_free;
    logic          e_v, sesc_p, sq_p, pq_p;
    logic [LW-1:0] pos_inc;

    // input byte decode
    assign acc       = cmd.take && s_tvalid;
    assign blank_now = start_reg ? (s_tdata == CH_CR || s_tdata == CH_LF) : blank_reg;
    assign closed    = !esc_reg && !inq_reg && (s_tdata == CH_COMMA);
    assign store     = !blank_now && !closed;
    assign room      = (len_reg < LEN_MAX);
    assign wr_en     = acc && store && room;
    assign nonws     = !is_ws(s_tdata);

    assign inq_next  = (acc && !blank_now && !esc_reg && s_tdata == CH_QUOTE) ? !inq_reg
                     : (cmd.put_stat || cmd.put_trail || (cmd.put_last && cmd.row_done))
                       ? 1'b0 : inq_reg;

    // replay: one buffered byte read per cycle unless the result side stalls, processed from the read register
    assign want_issue = any_reg && (ia_reg < hi_reg);
    assign pos_inc    = pos_reg + ONE;
    assign p_last     = (pos_inc == hi_reg);
    assign out_free   = !mv_reg || m_tready;
    assign proc_go    = cmd.scan && proc_v_reg && (!e_v || !hold_v_reg || out_free);
    assign issue      = cmd.scan && want_issue && (!proc_v_reg || proc_go);

    always_comb begin
        e_v    = 1'b0;
        sesc_p = sesc_reg;
        sq_p   = sq_reg;
        pq_p   = pq_reg;
        if (sesc_reg) begin
            e_v    = 1'b1;
            sesc_p = 1'b0;
            pq_p   = 1'b0;
        end else if (rd_data_reg == CH_BSL) begin
            sesc_p = 1'b1;
            pq_p   = 1'b0;
        end else if (rd_data_reg == CH_QUOTE) begin
            // a doubled quote inside quotes keeps one, unless it closes the field
            e_v = sq_reg && pq_reg && !p_last;
            if (sq_reg) begin
                pq_p = 1'b1;
            end else begin
                sq_p = 1'b1;
            end
        end else begin
            e_v  = 1'b1;
            pq_p = 1'b0;
        end
    end

    always_comb begin
        len_next    = len_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        any_next    = any_reg;
        esc_next    = esc_reg;
        start_next  = start_reg;
        blank_next  = blank_reg;
        ovf_next    = ovf_reg;
        ia_next     = ia_reg;
        pos_next    = pos_reg;
        proc_v_next = proc_v_reg;
        sesc_next   = sesc_reg;
        sq_next     = sq_reg;
        pq_next     = pq_reg;
        hold_v_next = hold_v_reg;
        hold_c_next = hold_c_reg;
        mv_next     = mv_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        ml_next     = ml_reg;
        md_next     = md_reg;
        ms_next     = ms_reg;

        if (acc) begin
            start_next = 1'b0;
            blank_next = blank_now;
            if (!blank_now) begin
                esc_next = !esc_reg && (s_tdata == CH_BSL);
                if (store) begin
                    if (room) begin
                        len_next = len_reg + ONE;
                        if (nonws) begin
                            if (!any_reg) begin
                                lo_next = len_reg;
                            end
                            hi_next  = len_reg + ONE;
                            any_next = 1'b1;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                if (closed || s_tlast) begin
                    ia_next     = lo_next;
                    proc_v_next = 1'b0;
                    sesc_next   = 1'b0;
                    sq_next     = 1'b0;
                    pq_next     = 1'b0;
                    hold_v_next = 1'b0;
                end
            end
        end

        if (issue) begin
            ia_next     = ia_reg + ONE;
            pos_next    = ia_reg;
            proc_v_next = 1'b1;
        end else if (proc_go) begin
            proc_v_next = 1'b0;
        end

        if (m_tready) begin
            mv_next = 1'b0;
        end

        if (proc_go) begin
            sesc_next = sesc_p;
            sq_next   = sq_p;
            pq_next   = pq_p;
            if (e_v) begin
                if (hold_v_reg) begin
                    mv_next = 1'b1;
                    mc_next = hold_c_reg;
                    mp_next = 1'b1;
                    ml_next = 1'b0;
                    md_next = 1'b0;
                    ms_next = ST_OK;
                end
                hold_v_next = 1'b1;
                hold_c_next = rd_data_reg;
            end
        end

        if (cmd.put_last) begin
            mv_next     = 1'b1;
            mc_next     = hold_v_reg ? hold_c_reg : 8'h00;
            mp_next     = hold_v_reg;
            ml_next     = 1'b1;
            md_next     = cmd.row_done;
            ms_next     = (cmd.row_done && ovf_reg) ? ST_OVF : ST_OK;
            hold_v_next = 1'b0;
            len_next    = '0;
            any_next    = 1'b0;
        end
        if (cmd.put_trail) begin
            mv_next = 1'b1;
            mc_next = 8'h00;
            mp_next = 1'b0;
            ml_next = 1'b1;
            md_next = 1'b1;
            ms_next = ovf_reg ? ST_OVF : ST_OK;
        end
        if (cmd.put_stat) begin
            mv_next = 1'b1;
            mc_next = 8'h00;
            mp_next = 1'b0;
            ml_next = 1'b0;
            md_next = 1'b1;
            ms_next = cmd.stat;
        end

        // end of row
        if (cmd.put_stat || cmd.put_trail || (cmd.put_last && cmd.row_done)) begin
            len_next   = '0;
            any_next   = 1'b0;
            esc_next   = 1'b0;
            start_next = 1'b1;
            blank_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            any_reg    <= 1'b0;
            inq_reg    <= 1'b0;
            esc_reg    <= 1'b0;
            start_reg  <= 1'b1;
            blank_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            ia_reg     <= '0;
            pos_reg    <= '0;
            proc_v_reg <= 1'b0;
            sesc_reg   <= 1'b0;
            sq_reg     <= 1'b0;
            pq_reg     <= 1'b0;
            hold_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            len_reg    <= len_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            any_reg    <= any_next;
            inq_reg    <= inq_next;
            esc_reg    <= esc_next;
            start_reg  <= start_next;
            blank_reg  <= blank_next;
            ovf_reg    <= ovf_next;
            ia_reg     <= ia_next;
            pos_reg    <= pos_next;
            proc_v_reg <= proc_v_next;
            sesc_reg   <= sesc_next;
            sq_reg     <= sq_next;
            pq_reg     <= pq_next;
            hold_v_reg <= hold_v_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_c_reg <= hold_c_next;
        mc_reg     <= mc_next;
        mp_reg     <= mp_next;
        ml_reg     <= ml_next;
        md_reg     <= md_next;
        ms_reg     <= ms_next;
    end

    // field buffer
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[len_reg[AW-1:0]] <= s_tdata;
        end
        if (issue) begin
            rd_data_reg <= mem[ia_reg[AW-1:0]];
        end
    end

    always_comb begin
        sts.ev_blank_end = blank_now && s_tlast;
        sts.ev_quote_err = !blank_now && !closed && s_tlast && inq_next;
        sts.ev_close     = !blank_now && closed;
        sts.ev_trail     = !blank_now && closed && s_tlast;
        sts.ev_field_end = !blank_now && !closed && s_tlast && !inq_next;
        sts.scan_end     = !want_issue && !proc_v_reg;
        sts.out_free     = out_free;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mc_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = {ms_reg, md_reg, mp_reg};

endmodule
`default_nettype wire

// ===== src/csvfs_sva.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csvfs_sva: port checks of the csv row field splitter
// Watches the result channel for handshake and field marking rules.
// ---------------------------------------------------------------------------
module csvfs_sva import csvfs_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [3:0] m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("empty beat carries a byte");

    a_status_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tuser[3:2] == ST_OK)
        else $error("status outside the row end beat");

    a_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:2] == ST_QUOTE || m_tuser[3:2] == ST_BLANK)
        |-> !m_tlast && !m_tuser[0])
        else $error("status-only beat marked as field data");

    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] && m_tuser[3:2] != ST_QUOTE && m_tuser[3:2] != ST_BLANK
        |-> m_tlast)
        else $error("row end beat does not close a field");

endmodule

bind csv_row_field_splitter_top csvfs_sva u_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== sim/csvfs_field_checker.sv =====
// ---------------------------------------------------------------------------
// csvfs_field_checker: scoreboard for the csv row field splitter
// Follows every accepted row byte with its own field splitter, queues the
// cleaned field beats that byte must produce and compares each beat taken on
// the result channel with the oldest one in the queue.
// ---------------------------------------------------------------------------
module csvfs_field_checker import csvfs_pkg::*; #(
    parameter int FIELD_MAX = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic       m_tlast,
    input  wire logic [3:0] m_tuser,
    output int              fail_count,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       present;
        logic       field_end;
        logic       row_end;
        logic [1:0] status;
    } field_beat_t;

    field_beat_t beats_due[$];

    logic [7:0]  field_buf [FIELD_MAX];
    int unsigned buf_len;
    bit          in_quotes;
    bit          escaped;
    bit          row_start;
    bit          blank_row;
    bit          overflowed;

    function automatic bit trim_char(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    task automatic queue_beat(input logic [7:0] ch, input bit present, input bit field_end,
                              input bit row_end, input logic [1:0] status);
        field_beat_t b;
        b.ch        = ch;
        b.present   = present;
        b.field_end = field_end;
        b.row_end   = row_end;
        b.status    = status;
        beats_due = {beats_due, b};
    endtask

    task automatic clear_row();
        buf_len    = 0;
        in_quotes  = 1'b0;
        escaped    = 1'b0;
        row_start  = 1'b1;
        blank_row  = 1'b0;
        overflowed = 1'b0;
    endtask

    task automatic buffer_byte(input logic [7:0] c);
        if (buf_len < FIELD_MAX) begin
            field_buf[buf_len] = c;
            buf_len++;
        end else begin
            overflowed = 1'b1;
        end
    endtask

    // trim, strip quotes and escapes, then queue the field beat by beat
    task automatic replay_field(input bit closes_row, input logic [1:0] st);
        logic [7:0]  kept [$];
        int unsigned lo, hi, n, j;
        bit          opened;
        bit          tail;
        lo = 0;
        hi = buf_len;
        j = 0;
        opened = 1'b0;
        while (lo < hi && trim_char(field_buf[lo])) lo++;
        while (hi > lo && trim_char(field_buf[hi-1])) hi--;
        n = hi - lo;
        while (j < n) begin
            if (field_buf[lo+j] == CH_QUOTE) begin
                // a doubled quote inside a quoted run keeps one quote
                if (opened && j + 2 < n && field_buf[lo+j+1] == CH_QUOTE)
                    kept = {kept, CH_QUOTE};
                else
                    opened = 1'b1;
                j++;
            end else if (field_buf[lo+j] == CH_BSL) begin
                if (j + 1 < n)
                    kept = {kept, field_buf[lo+j+1]};
                j += 2;
            end else begin
                kept = {kept, field_buf[lo+j]};
                j++;
            end
        end
        buf_len = 0;
        if (kept.size() == 0) begin
            queue_beat(8'h00, 1'b0, 1'b1, closes_row, closes_row ? st : ST_OK);
        end else begin
            foreach (kept[i]) begin
                tail = (i == kept.size() - 1);
                queue_beat(kept[i], 1'b1, tail, closes_row && tail,
                           (closes_row && tail) ? st : ST_OK);
            end
        end
    endtask

    task automatic split_byte(input logic [7:0] c, input bit last);
        bit         closed;
        logic [1:0] st;
        closed = 1'b0;
        if (row_start) begin
            row_start = 1'b0;
            if (c == CH_CR || c == CH_LF)
                blank_row = 1'b1;
        end
        if (blank_row) begin
            if (last) begin
                queue_beat(8'h00, 1'b0, 1'b0, 1'b1, ST_BLANK);
                clear_row();
            end
        end else begin
            if (escaped) begin
                escaped = 1'b0;
                buffer_byte(c);
            end else if (c == CH_BSL) begin
                escaped = 1'b1;
                buffer_byte(c);
            end else if (c == CH_QUOTE) begin
                in_quotes = !in_quotes;
                buffer_byte(c);
            end else if (c == CH_COMMA && !in_quotes) begin
                closed = 1'b1;
            end else begin
                buffer_byte(c);
            end
            st = overflowed ? ST_OVF : ST_OK;
            if (closed) begin
                replay_field(1'b0, ST_OK);
                // trailing comma adds an empty field that ends the row
                if (last) begin
                    queue_beat(8'h00, 1'b0, 1'b1, 1'b1, st);
                    clear_row();
                end
            end else if (last) begin
                if (in_quotes)
                    queue_beat(8'h00, 1'b0, 1'b0, 1'b1, ST_QUOTE);
                else
                    replay_field(1'b1, st);
                clear_row();
            end
        end
    endtask

    task automatic compare_beat();
        field_beat_t want;
        if (beats_due.size() == 0) begin
            $error("result beat with nothing expected: tdata %02h tlast %0d tuser %04b",
                   m_tdata, m_tlast, m_tuser);
            fail_count++;
        end else begin
            want = beats_due.pop_front();
            if (m_tdata !== want.ch) begin
                $error("out_char: expected %02h, got %02h", want.ch, m_tdata);
                fail_count++;
            end
            if (m_tuser[0] !== want.present) begin
                $error("char_present: expected %0d, got %0d", want.present, m_tuser[0]);
                fail_count++;
            end
            if (m_tlast !== want.field_end) begin
                $error("field_last: expected %0d, got %0d", want.field_end, m_tlast);
                fail_count++;
            end
            if (m_tuser[1] !== want.row_end) begin
                $error("row_done: expected %0d, got %0d", want.row_end, m_tuser[1]);
                fail_count++;
            end
            if (m_tuser[3:2] !== want.status) begin
                $error("row_status: expected %0d, got %0d", want.status, m_tuser[3:2]);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_row();
            beats_due.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready)
                compare_beat();
            if (s_tvalid && s_tready)
                split_byte(s_tdata, s_tlast);
        end
        pending <= beats_due.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: csv row field splitter
// Feeds directed rows covering empty fields, trailing commas, doubled quotes,
// escapes, trimming, blank rows and unmatched quotes, then random rows of
// mostly well-formed fields with some noise, with random gaps on both
// channels, a long result back-pressure and a full drain pause.
// ---------------------------------------------------------------------------
module testbench import csvfs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        FK_PLAIN,
        FK_PADDED,
        FK_QUOTED,
        FK_ESCAPED,
        FK_NOISE,
        FK_LONG
    } field_kind_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [3:0] m_tuser;

    int         fail_count;
    int         pending;
    bit         gaps_on;
    bit         hold_req;
    logic [7:0] row_q[$];
    int         bytes_sent;

    csv_row_field_splitter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    csvfs_field_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, plus a counted hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
            end
            m_tready <= !(gaps_on && $urandom_range(99) < 35);
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_COMMA || c == CH_QUOTE || c == CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] pad_byte();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    function automatic field_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return FK_PLAIN;
        if (r < 50) return FK_PADDED;
        if (r < 70) return FK_QUOTED;
        if (r < 85) return FK_ESCAPED;
        if (r < 95) return FK_NOISE;
        return FK_LONG;
    endfunction

    task automatic add_byte(input logic [7:0] c);
        row_q = {row_q, c};
    endtask

    task automatic push_byte(input logic [7:0] c, input bit last);
        while (gaps_on && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_row();
        for (int i = 0; i < row_q.size(); i++)
            push_byte(row_q[i], i == row_q.size() - 1);
        // a blank row only counts its final byte
        if (row_q[0] == CH_CR || row_q[0] == CH_LF)
            bytes_sent += 1;
        else
            bytes_sent += row_q.size();
        row_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
        send_row();
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk);
        while (pending != 0);
    endtask

    task automatic add_field(input field_kind_t kind);
        int unsigned len;
        len = $urandom_range(0, 6);
        case (kind)
            FK_PLAIN: begin
                repeat (len) add_byte(text_byte());
            end
            FK_PADDED: begin
                repeat ($urandom_range(0, 2)) add_byte(pad_byte());
                repeat (len) add_byte(text_byte());
                repeat ($urandom_range(0, 2)) add_byte(pad_byte());
            end
            FK_QUOTED: begin
                if ($urandom_range(3) == 0) add_byte(CH_SPACE);
                add_byte(CH_QUOTE);
                repeat (len) begin
                    case ($urandom_range(9))
                        0: add_byte(CH_COMMA);
                        1: add_byte(CH_SPACE);
                        2: begin
                            add_byte(CH_QUOTE);
                            add_byte(CH_QUOTE);
                        end
                        default: add_byte(text_byte());
                    endcase
                end
                add_byte(CH_QUOTE);
                if ($urandom_range(3) == 0) add_byte(CH_TAB);
            end
            FK_ESCAPED: begin
                repeat (len) begin
                    if ($urandom_range(2) == 0) begin
                        add_byte(CH_BSL);
                        add_byte(rand_byte());
                    end else begin
                        add_byte(text_byte());
                    end
                end
            end
            FK_NOISE: begin
                repeat (len) add_byte(rand_byte());
            end
            default: begin
                // longer than the field buffer
                repeat ($urandom_range(33, 44)) add_byte(text_byte());
            end
        endcase
    endtask

    task automatic build_row(input int unsigned n_fields);
        int unsigned shape;
        shape = $urandom_range(99);
        if (shape < 8) begin
            add_byte($urandom_range(1) ? CH_CR : CH_LF);
            repeat ($urandom_range(0, 5)) add_byte(rand_byte());
        end else if (shape < 16) begin
            repeat ($urandom_range(1, 12)) add_byte(rand_byte());
        end else begin
            for (int k = 0; k < n_fields; k++) begin
                if (k != 0) add_byte(CH_COMMA);
                add_field(pick_kind());
            end
            if (shape < 24) begin
                // quote left open to the end of the row
                add_byte(CH_COMMA);
                add_byte(CH_QUOTE);
                add_field(FK_PLAIN);
            end else if ($urandom_range(4) == 0) begin
                add_byte(CH_COMMA);
            end
        end
        if (row_q.size() == 0) add_byte(text_byte());
    endtask

    initial begin
        int row_no;
        int drain;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        send_text("a,,b,");
        send_text("\"a\"\"b\"");
        send_text("\nz");
        add_byte(CH_CR);
        send_row();
        send_text("\"a");
        send_text("\\,\\");
        send_text(" b\t");
        add_byte(8'h00);
        add_byte(8'hFF);
        send_row();
        drain_results();

        // random rows
        bytes_sent = 0;
        row_no = 0;
        while (bytes_sent < 380) begin
            gaps_on = !(row_no >= 14 && row_no < 22);
            if (row_no == 0) begin
                add_field(FK_LONG);
                add_byte(CH_COMMA);
                add_field(FK_PLAIN);
                send_row();
            end else if (row_no == 4) begin
                // hold the result side while a wide row keeps arriving
                hold_req <= 1'b1;
                for (int k = 0; k < 8; k++) begin
                    if (k != 0) add_byte(CH_COMMA);
                    add_field(FK_PLAIN);
                end
                add_byte(text_byte());
                send_row();
            end else begin
                build_row($urandom_range(1, 5));
                send_row();
            end
            if (row_no == 9 || row_no == 26)
                drain_results();
            row_no++;
        end

        gaps_on = 1'b1;
        s_tvalid <= 1'b0;
        drain = 0;
        do begin
            @(posedge aclk);
            drain++;
        end while (pending != 0 && drain < 20000);
        repeat (50) @(posedge aclk);
        if (pending != 0)
            $error("%0d result beats never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
